>>> design/keyboard_display_controller_regs_assert.svh
// Assertion macros for the keyboard/display controller register block.
`ifndef KEYBOARD_DISPLAY_CONTROLLER_REGS_ASSERT_SVH
`define KEYBOARD_DISPLAY_CONTROLLER_REGS_ASSERT_SVH

// same-cycle implication
`define KDC_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("kdc: implication check failed");

// delayed implication
`define KDC_ASSERT_DELAY2(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> ##2 (rhs)) \
      else $error("kdc: two-cycle latency check failed");

`endif

>>> design/kdc_pkg.sv
// Shared types and constants for the keyboard/display controller register block.
`timescale 1ns / 1ps
`default_nettype none

package kdc_pkg;

   localparam int DISP_ENTRIES = 16;
   localparam int DISP_IDX_W   = $clog2(DISP_ENTRIES);
   localparam int DISP_PTR_W   = DISP_IDX_W + 1;

   localparam logic [7:0] KEY_NONE    = 8'hFF;
   localparam logic [1:0] CLEAR_BITS  = 2'b11;

   // item selector
   typedef enum logic [2:0] {
      CMD_READ_KEY    = 3'd0,
      CMD_READ_STATUS = 3'd1,
      CMD_WRITE_DATA  = 3'd2,
      CMD_WRITE_CMD   = 3'd3,
      CMD_KEY_EVENT   = 3'd4,
      CMD_NO_KEY      = 3'd5
   } cmd_type;

   // command word opcode, bits 7:5
   typedef enum logic [2:0] {
      OP_MODE_SET   = 3'b000,
      OP_DISP_WRITE = 3'b100,
      OP_CLEAR      = 3'b110
   } cmd_op_type;

endpackage

`default_nettype wire

>>> design/keyboard_display_controller_regs.sv
// Keyboard/display controller register block: bus accesses and key events.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------------
//   request  | req_cmd, req_data_byte                  | start high, busy low
//   response | rsp_read_data, rsp_disp_written,        | rsp_valid, one cycle,
//            | rsp_disp_index, rsp_disp_value,         | cannot be held off
//            | rsp_disp_cleared                        |
//
// One item per cycle while busy is low; each item gives one response, passing the input
// register, then decode and state update into the response register.
// busy is high during reset and in the first cycle after it; reset clears pointer,
// mode, key and status registers. Display entries themselves live downstream and
// follow the write and clear strobes on the response.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_display_controller_regs (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [2:0]                    req_cmd,
   input  wire logic [7:0]                    req_data_byte,
   output logic                               rsp_valid,
   output logic [7:0]                         rsp_read_data,
   output logic                               rsp_disp_written,
   output logic [kdc_pkg::DISP_IDX_W-1:0]     rsp_disp_index,
   output logic [7:0]                         rsp_disp_value,
   output logic                               rsp_disp_cleared
);
   import kdc_pkg::*;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [2:0]            in_cmd_ff;
   logic [7:0]            in_data_ff;
   logic                  busy_ff;

   // controller state
   logic [DISP_IDX_W-1:0] ptr_ff, ptr_in;
   logic                  auto_ff, auto_in;
   logic                  lim_set_ff, lim_set_in;   // limit nonzero
   logic                  lim_16_ff, lim_16_in;     // 16 entries, else 8
   logic [7:0]            key_ff, key_in;
   logic                  status_ff, status_in;     // status byte is 0 or 1

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rd_ff, rd_in;
   logic                  wr_ff, wr_in;
   logic [DISP_IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]            val_ff, val_in;
   logic                  clr_ff, clr_in;

   cmd_type               cmd;
   cmd_op_type            op;
   logic [DISP_PTR_W-1:0] ptr_next;
   logic [DISP_PTR_W-1:0] limit;

   assign in_valid_in = start && !busy_ff;
   assign cmd         = cmd_type'(in_cmd_ff);
   assign op          = cmd_op_type'(in_data_ff[7:5]);
   assign ptr_next    = {1'b0, ptr_ff} + DISP_PTR_W'(1);
   assign limit       = !lim_set_ff ? DISP_PTR_W'(0) :
                        (lim_16_ff ? DISP_PTR_W'(DISP_ENTRIES) : DISP_PTR_W'(DISP_ENTRIES / 2));

   always_comb begin
      ptr_in       = ptr_ff;
      auto_in      = auto_ff;
      lim_set_in   = lim_set_ff;
      lim_16_in    = lim_16_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      rsp_valid_in = in_valid_ff;
      rd_in        = 8'd0;
      wr_in        = 1'b0;
      idx_in       = '0;
      val_in       = 8'd0;
      clr_in       = 1'b0;
      if (in_valid_ff) begin
         unique case (cmd)
            CMD_READ_KEY: begin
               rd_in     = key_ff;
               status_in = 1'b0;
            end
            CMD_READ_STATUS: begin
               rd_in = {7'd0, status_ff};
            end
            CMD_WRITE_DATA: begin
               wr_in  = 1'b1;
               idx_in = ptr_ff;
               val_in = in_data_ff;
               if (auto_ff) begin
                  ptr_in = (ptr_next >= limit) ? '0 : ptr_next[DISP_IDX_W-1:0];
               end
            end
            CMD_WRITE_CMD: begin
               unique case (op)
                  OP_MODE_SET: begin
                     lim_set_in = 1'b1;
                     lim_16_in  = in_data_ff[3];
                  end
                  OP_DISP_WRITE: begin
                     auto_in = in_data_ff[4];
                     ptr_in  = in_data_ff[DISP_IDX_W-1:0];
                  end
                  OP_CLEAR: begin
                     clr_in = (in_data_ff[3:2] == CLEAR_BITS);
                  end
                  default: ;
               endcase
            end
            CMD_KEY_EVENT: begin
               key_in    = in_data_ff;
               status_in = 1'b1;
            end
            CMD_NO_KEY: begin
               key_in = KEY_NONE;
            end
            default: ;   // unused selectors do nothing
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         in_valid_ff  <= 1'b0;
         ptr_ff       <= '0;
         auto_ff      <= 1'b0;
         lim_set_ff   <= 1'b0;
         lim_16_ff    <= 1'b0;
         key_ff       <= 8'd0;
         status_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_ff        <= 8'd0;
         wr_ff        <= 1'b0;
         idx_ff       <= '0;
         val_ff       <= 8'd0;
         clr_ff       <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         in_valid_ff  <= in_valid_in;
         ptr_ff       <= ptr_in;
         auto_ff      <= auto_in;
         lim_set_ff   <= lim_set_in;
         lim_16_ff    <= lim_16_in;
         key_ff       <= key_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         idx_ff       <= idx_in;
         val_ff       <= val_in;
         clr_ff       <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      in_cmd_ff  <= req_cmd;
      in_data_ff <= req_data_byte;
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rd_ff;
   assign rsp_disp_written = wr_ff;
   assign rsp_disp_index   = idx_ff;
   assign rsp_disp_value   = val_ff;
   assign rsp_disp_cleared = clr_ff;

`include "keyboard_display_controller_regs_assert.svh"

   `KDC_ASSERT_DELAY2(a_rsp_latency, clock, reset, start && !busy, rsp_valid)
   `KDC_ASSERT_IMPLY(a_one_action, clock, reset, rsp_valid,
      !(rsp_disp_written && rsp_disp_cleared) && !(rsp_disp_written && rsp_read_data != 8'd0))
   `KDC_ASSERT_IMPLY(a_quiet_idle, clock, reset, !rsp_valid,
      !rsp_disp_written && !rsp_disp_cleared && rsp_read_data == 8'd0)
   `KDC_ASSERT_IMPLY(a_ptr_in_limit, clock, reset,
      lim_set_ff && !lim_16_ff && auto_ff && $past(in_valid_ff && cmd == CMD_WRITE_DATA),
      !ptr_ff[DISP_IDX_W-1])

endmodule

`default_nettype wire
